/* rtl/core/i2c_master_transfer_sequencer_macros.svh */
// Assertion macros shared by the I2C master transfer sequencer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/i2c_mts_pkg.sv */
// Package for the I2C master transfer sequencer: item and result types
// and the default counter width. Depends on nothing.
package i2c_mts_pkg;

    // Default width of the byte counters.
    localparam int unsigned COUNT_BITS_DEF = 16;

    // One input item as captured by the input register.
    typedef struct packed {
        logic        func;
        logic [7:0]  slave_addr;
        logic [15:0] length;
        logic        trailing_stop;
        logic [7:0]  status;
        logic [7:0]  rx_data;
        logic [7:0]  tx_data;
    } item_t;

    // One action word handed to the output register.
    typedef struct packed {
        logic        assert_start;
        logic        load_data;
        logic [7:0]  data_out;
        logic        clear_start;
        logic        set_ack;
        logic        clear_ack;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic [15:0] byte_index;
        logic        finished;
        logic        result_code;
        logic        send_stop;
    } result_t;

endpackage

/* rtl/core/i2c_mts_in_reg.sv */
// Input register of the I2C master transfer sequencer.
// Depends on i2c_mts_pkg for the item type.
module i2c_mts_in_reg
    import i2c_mts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The register is free when empty or when its item moves on this cycle.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/i2c_mts_ctrl.sv */
// Transfer state and status-code decode of the I2C master sequencer.
// Depends on i2c_mts_pkg and the assertion macro header.
`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_mts_ctrl
    import i2c_mts_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    // Controller status codes.
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    // Wide enough for both the length field and the counters.
    localparam int unsigned WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  active_reg;
    logic                  active_next;
    logic [7:0]            addr_reg;
    logic [7:0]            addr_next;
    logic [COUNT_BITS-1:0] remaining_reg;
    logic [COUNT_BITS-1:0] remaining_next;
    logic [COUNT_BITS-1:0] position_reg;
    logic [COUNT_BITS-1:0] position_next;
    logic                  stop_reg;
    logic                  stop_next;

    logic [WIDE-1:0]       len_wide;
    logic [WIDE-1:0]       pos_wide;
    logic [COUNT_BITS-1:0] rem_dec;
    logic [COUNT_BITS-1:0] pos_inc;
    logic [15:0]           index;

    // Length is cut to the counter width; the index is the low 16 bits
    // of the position.
    assign len_wide = WIDE'(item.length);
    assign pos_wide = WIDE'(position_reg);
    assign index    = pos_wide[15:0];
    assign rem_dec  = remaining_reg - COUNT_BITS'(1);
    assign pos_inc  = position_reg + COUNT_BITS'(1);

    // Decode of one item against the current transfer state.
    always_comb
    begin
        res            = '0;
        active_next    = active_reg;
        addr_next      = addr_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        stop_next      = stop_reg;

        if (!item.func)
        begin
            // A start item opens a transfer, dropping any open one.
            active_next      = 1'b1;
            addr_next        = item.slave_addr;
            remaining_next   = len_wide[COUNT_BITS-1:0];
            position_next    = '0;
            stop_next        = item.trailing_stop;
            res.assert_start = 1'b1;
        end
        else if (active_reg)
        begin
            case (item.status)
                ST_START, ST_RSTART:
                begin
                    res.load_data   = 1'b1;
                    res.data_out    = addr_reg;
                    res.clear_start = 1'b1;
                end
                ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_ADDR_R_NACK:
                begin
                    // Errors always end the transfer with STOP.
                    res.finished    = 1'b1;
                    res.result_code = 1'b1;
                    res.send_stop   = 1'b1;
                    active_next     = 1'b0;
                end
                ST_ADDR_W_ACK, ST_DATA_W_ACK:
                begin
                    if (remaining_reg != '0)
                    begin
                        res.load_data  = 1'b1;
                        res.data_out   = item.tx_data;
                        res.byte_index = index;
                        position_next  = pos_inc;
                        remaining_next = rem_dec;
                    end
                    else
                    begin
                        res.finished  = 1'b1;
                        res.send_stop = stop_reg;
                        active_next   = 1'b0;
                    end
                end
                ST_ADDR_R_ACK:
                begin
                    res.set_ack = 1'b1;
                end
                ST_DATA_R_ACK, ST_DATA_R_NACK:
                begin
                    // A count of zero wraps and the read goes on.
                    res.rx_valid   = 1'b1;
                    res.rx_byte    = item.rx_data;
                    res.byte_index = index;
                    position_next  = pos_inc;
                    remaining_next = rem_dec;
                    if (rem_dec == COUNT_BITS'(1))
                    begin
                        res.clear_ack = 1'b1;
                    end
                    else if (rem_dec == '0)
                    begin
                        res.finished  = 1'b1;
                        res.send_stop = stop_reg;
                        active_next   = 1'b0;
                    end
                end
                default:
                begin
                    // Unknown codes leave everything as it is.
                    res = '0;
                end
            endcase
        end
    end

    // State advances only when an item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            addr_reg      <= '0;
            remaining_reg <= '0;
            position_reg  <= '0;
            stop_reg      <= 1'b0;
        end
        else if (fire)
        begin
            active_reg    <= active_next;
            addr_reg      <= addr_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            stop_reg      <= stop_next;
        end
    end

    // Checks on the transfer state.
    `MTS_ASSERT_NEXT(a_finish_closes, clk, rst_n, fire && res.finished, !active_reg, "finished transfer stayed open")
    `MTS_ASSERT_NEXT(a_start_opens, clk, rst_n, fire && !item.func, active_reg && (position_reg == '0), "start item did not open a clean transfer")
    `MTS_ASSERT_NOW(a_idle_silent, clk, rst_n, fire && item.func && !active_reg, res == '0, "status item while idle produced an action")
    `MTS_ASSERT_NOW(a_stop_on_end, clk, rst_n, res.send_stop || res.result_code, res.finished, "stop or error flagged without finish")

endmodule

/* rtl/core/i2c_mts_out_reg.sv */
// Result register of the I2C master transfer sequencer.
// Depends on i2c_mts_pkg for the result type.
module i2c_mts_out_reg
    import i2c_mts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  result_t res,
    output logic    take,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    fire;

    // A new result may enter when empty or when the held one leaves.
    assign take = !valid_reg || !out_stall;
    assign fire = item_valid && take;

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* rtl/core/i2c_master_transfer_sequencer.sv */
// Top level of the I2C master transfer sequencer.
// Depends on i2c_mts_pkg, i2c_mts_in_reg, i2c_mts_ctrl and i2c_mts_out_reg.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    func slave_addr length trailing_stop
//                                    status rx_data tx_data
//   output    out_valid / out_stall  assert_start load_data data_out
//                                    clear_start set_ack clear_ack rx_valid
//                                    rx_byte byte_index finished
//                                    result_code send_stop
//
// One item per cycle sustained while out_stall is low; each item gives
// exactly one result. From acceptance to out_valid, the input register
// takes the item, and one pass of status decode and counter update
// fills the result register once that register can take a new result.
// rst_n clears the transfer state and both valid flags at once.
// A stall on the output holds the result and backs up into in_stall.
module i2c_master_transfer_sequencer
    import i2c_mts_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  slave_addr,
    input  logic [15:0] length,
    input  logic        trailing_stop,
    input  logic [7:0]  status,
    input  logic [7:0]  rx_data,
    input  logic [7:0]  tx_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        assert_start,
    output logic        load_data,
    output logic [7:0]  data_out,
    output logic        clear_start,
    output logic        set_ack,
    output logic        clear_ack,
    output logic        rx_valid,
    output logic [7:0]  rx_byte,
    output logic [15:0] byte_index,
    output logic        finished,
    output logic        result_code,
    output logic        send_stop
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t res;
    result_t out_res;

    // Gather the input fields into one item.
    assign in_item.func          = func;
    assign in_item.slave_addr    = slave_addr;
    assign in_item.length        = length;
    assign in_item.trailing_stop = trailing_stop;
    assign in_item.status        = status;
    assign in_item.rx_data       = rx_data;
    assign in_item.tx_data       = tx_data;

    i2c_mts_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    i2c_mts_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (item_valid && take),
        .item  (item),
        .res   (res)
    );

    i2c_mts_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    // Spread the held result onto the output fields.
    assign assert_start = out_res.assert_start;
    assign load_data    = out_res.load_data;
    assign data_out     = out_res.data_out;
    assign clear_start  = out_res.clear_start;
    assign set_ack      = out_res.set_ack;
    assign clear_ack    = out_res.clear_ack;
    assign rx_valid     = out_res.rx_valid;
    assign rx_byte      = out_res.rx_byte;
    assign byte_index   = out_res.byte_index;
    assign finished     = out_res.finished;
    assign result_code  = out_res.result_code;
    assign send_stop    = out_res.send_stop;

endmodule
